// ----- design/fsq_pkg.sv -----
// Shared types and constants for the FIFO / shortest-first request queue.
// No dependencies; compiled before every other file of the block.
package fsq_pkg;

  localparam int ID_W     = 16;
  localparam int LEN_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;

  // Opcodes of an input transaction
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // Configuration register indexes and values
  localparam logic CFG_POLICY   = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_SJN  = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command broadcast from the controller to every cell
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_REMOVE = 2'd2
  } fsq_op_t;

  typedef struct packed {
    fsq_op_t           op;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } fsq_cmd_t;

  // Running-minimum token that walks along the cell chain
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } fsq_tok_t;

endpackage

// ----- design/fsq_in_if.sv -----
// Input channel of the request queue: valid/ready handshake with request payload.
// Depends on fsq_pkg for field widths.
interface fsq_in_if;
  import fsq_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ID_W-1:0]   request_id;
  logic [LEN_W-1:0]  request_length;

  modport source (output valid, output opcode, output request_id, output request_length,
                  input ready);
  modport sink   (input valid, input opcode, input request_id, input request_length,
                  output ready);
endinterface

// ----- design/fsq_out_if.sv -----
// Result channel of the request queue: valid/ready handshake with status payload.
// Depends on fsq_pkg for field widths.
interface fsq_out_if;
  import fsq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      out_id;
  logic [LEN_W-1:0]     out_length;

  modport source (output valid, output status, output out_id, output out_length,
                  input ready);
  modport sink   (input valid, input status, input out_id, input out_length,
                  output ready);
endinterface

// ----- design/fsq_cell.sv -----
// One queue slot of the cell chain: holds an entry, loads on push, closes up on
// removal and passes the running-minimum token on. Depends on fsq_pkg.
module fsq_cell #(
  parameter int IDX_W = 4,
  parameter int POS   = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fsq_pkg::fsq_cmd_t         cmd,
  input  logic [IDX_W-1:0]          rm_pos,
  input  logic                      prev_valid,
  input  logic                      next_valid,
  input  logic [fsq_pkg::ID_W-1:0]  next_id,
  input  logic [fsq_pkg::LEN_W-1:0] next_len,
  input  fsq_pkg::fsq_tok_t         tok_in,
  input  logic [IDX_W-1:0]          tok_pos_in,
  output fsq_pkg::fsq_tok_t         tok_out,
  output logic [IDX_W-1:0]          tok_pos_out,
  output logic                      valid,
  output logic [fsq_pkg::ID_W-1:0]  id,
  output logic [fsq_pkg::LEN_W-1:0] len
);
  import fsq_pkg::*;

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  fsq_tok_t          tok_r, tok_nxt;
  logic [IDX_W-1:0]  tok_pos_r, tok_pos_nxt;

  // Load on push into the first free slot, close up on removal at or below us
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    case (cmd.op)
      CMD_PUSH: begin
        if (!valid_r && prev_valid) begin
          valid_nxt = 1'b1;
          id_nxt    = cmd.id;
          len_nxt   = cmd.len;
        end
      end
      CMD_REMOVE: begin
        if (rm_pos <= MY_POS) begin
          valid_nxt = next_valid;
          id_nxt    = next_id;
          len_nxt   = next_len;
        end
      end
      default: ;
    endcase
  end

  // Replace the token's best entry when ours is strictly shorter (ties stay oldest)
  always_comb begin
    tok_nxt     = tok_in;
    tok_pos_nxt = tok_pos_in;
    if (tok_in.valid && valid_r && (!tok_in.found || (len_r < tok_in.len))) begin
      tok_nxt.found = 1'b1;
      tok_nxt.id    = id_r;
      tok_nxt.len   = len_r;
      tok_pos_nxt   = MY_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    len_r     <= len_nxt;
    tok_pos_r <= tok_pos_nxt;
  end

  assign valid       = valid_r;
  assign id          = id_r;
  assign len         = len_r;
  assign tok_out     = tok_r;
  assign tok_pos_out = tok_pos_r;

endmodule

// ----- design/fifo_or_shortest_first_queue.sv -----
// Bounded request queue with FIFO or shortest-length-first dequeue, built as a cell chain.
// Enqueue, empty dequeue and FIFO dequeue: result registered in the cycle after acceptance,
// one transaction per cycle while the result side keeps up.
// Shortest-first dequeue: the minimum token walks the chain one cell per cycle, then the
// chosen entry is emitted once the result side is free and the younger cells close up.
// Synchronous reset clears all slots, occupancy and results; policy FIFO, capacity 16.
module fifo_or_shortest_first_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  fsq_in_if.sink                    in_ch,
  fsq_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [fsq_pkg::CAP_W-1:0] cfg_wdata
);
  import fsq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EMIT = 2'd2
  } state_t;

  // Configuration registers
  logic              policy_r;
  logic [CAP_W-1:0]  capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= POLICY_FIFO;
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:   policy_r   <= cfg_wdata[0];
        CFG_CAPACITY: capacity_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Chain wiring
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [ID_W-1:0]        cell_id  [QUEUE_DEPTH];
  logic [LEN_W-1:0]       cell_len [QUEUE_DEPTH];
  fsq_tok_t               tok      [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]       tok_pos  [QUEUE_DEPTH+1];
  fsq_tok_t               scan_tok;
  fsq_cmd_t               cmd;
  logic [IDX_W-1:0]       rm_pos;

  // Feed the scan start token into the head of the chain
  assign tok[0]     = scan_tok;
  assign tok_pos[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic              nb_valid;
    logic [ID_W-1:0]   nb_id;
    logic [LEN_W-1:0]  nb_len;
    logic              pv_valid;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb_valid = 1'b0;
      assign nb_id    = '0;
      assign nb_len   = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[i+1];
      assign nb_id    = cell_id[i+1];
      assign nb_len   = cell_len[i+1];
    end

    if (i == 0) begin : g_first
      assign pv_valid = 1'b1;
    end else begin : g_rest
      assign pv_valid = cell_valid[i-1];
    end

    fsq_cell #(
      .IDX_W (IDX_W),
      .POS   (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .rm_pos      (rm_pos),
      .prev_valid  (pv_valid),
      .next_valid  (nb_valid),
      .next_id     (nb_id),
      .next_len    (nb_len),
      .tok_in      (tok[i]),
      .tok_pos_in  (tok_pos[i]),
      .tok_out     (tok[i+1]),
      .tok_pos_out (tok_pos[i+1]),
      .valid       (cell_valid[i]),
      .id          (cell_id[i]),
      .len         (cell_len[i])
    );
  end

  // Effective capacity: saturate to 1..QUEUE_DEPTH
  logic [CMP_W-1:0] cap_ext, eff_cap;
  logic             full;

  assign cap_ext = CMP_W'(capacity_r);
  assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
                   ((cap_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : cap_ext);

  // Controller state and result registers
  state_t            state_r, state_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [IDX_W-1:0]  best_pos_r, best_pos_nxt;
  logic              out_free, in_fire;

  assign full     = CMP_W'(occ_r) >= eff_cap;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Decode the transaction, drive the cell command and the scan start token
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    out_id_nxt    = out_id_r;
    out_len_nxt   = out_len_r;
    best_id_nxt   = best_id_r;
    best_len_nxt  = best_len_r;
    best_pos_nxt  = best_pos_r;
    cmd.op        = CMD_NONE;
    cmd.id        = in_ch.request_id;
    cmd.len       = in_ch.request_length;
    rm_pos        = '0;
    scan_tok      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_len_nxt   = '0;
          if (in_ch.opcode == OP_ENQUEUE) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_ACCEPTED;
              cmd.op     = CMD_PUSH;
              occ_nxt    = occ_r + OCC_W'(1);
            end
          end else if (occ_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (policy_r == POLICY_FIFO) begin
            status_nxt  = ST_DEQUEUED;
            out_id_nxt  = cell_id[0];
            out_len_nxt = cell_len[0];
            cmd.op      = CMD_REMOVE;
            occ_nxt     = occ_r - OCC_W'(1);
          end else begin
            // Launch the minimum search; result comes later
            out_valid_nxt  = 1'b0;
            scan_tok.valid = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Capture the winner as the token leaves the last cell
        if (tok[QUEUE_DEPTH].valid) begin
          best_id_nxt  = tok[QUEUE_DEPTH].id;
          best_len_nxt = tok[QUEUE_DEPTH].len;
          best_pos_nxt = tok_pos[QUEUE_DEPTH];
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DEQUEUED;
          out_id_nxt    = best_id_r;
          out_len_nxt   = best_len_r;
          cmd.op        = CMD_REMOVE;
          rm_pos        = best_pos_r;
          occ_nxt       = occ_r - OCC_W'(1);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r   <= status_nxt;
    out_id_r   <= out_id_nxt;
    out_len_r  <= out_len_nxt;
    best_id_r  <= best_id_nxt;
    best_len_r <= best_len_nxt;
    best_pos_r <= best_pos_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.out_id     = out_id_r;
  assign out_ch.out_length = out_len_r;

  // Occupancy tracks the number of filled cells
  a_occ_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(occ_r))
    else $error("occupancy differs from filled cell count");

  // Filled cells are packed from the head end with no gaps
  a_cells_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + QUEUE_DEPTH'(1)) & cell_valid) == '0)
    else $error("gap in the cell chain");

  // A token reaching the end of the chain always carries a winner
  a_tok_found: assert property (@(posedge clk) disable iff (!rst_n)
    tok[QUEUE_DEPTH].valid |-> (tok[QUEUE_DEPTH].found && state_r == S_SCAN))
    else $error("scan token finished without a winner or outside a scan");

  // A shortest-first dequeue reduces occupancy by one once emitted
  a_emit_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (occ_r == $past(occ_r) - OCC_W'(1)))
    else $error("emit did not remove an entry");

  // Occupancy never exceeds the storage depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(occ_r) <= CMP_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

endmodule

// ----- sim/fifo_or_shortest_first_queue_tb.sv -----
// Self-checking testbench for the FIFO / shortest-first request queue.
// Drives random and directed transactions through fsq_in_if, checks fsq_out_if
// against an in-bench queue predictor; depends on fsq_pkg and the two interfaces.
`timescale 1ns / 1ps

module fifo_or_shortest_first_queue_tb;
  import fsq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 65;
  localparam int NUM_PHASES  = 6;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } held_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [LEN_W-1:0]    len;
  } qresult_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [CAP_W-1:0] cfg_wdata;

  fsq_in_if  in_bus ();
  fsq_out_if out_bus ();

  fifo_or_shortest_first_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: held requests in age order, oldest first
  held_req_t        held_reqs[$];
  logic             policy_reg;
  logic [CAP_W-1:0] capacity_reg;

  request_t pending_reqs[$];
  qresult_t expected_results[$];

  int total_queued;
  int results_seen;
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  // Work out the result of one accepted transaction and update the held requests
  function automatic qresult_t serve_request(request_t req);
    qresult_t  res;
    held_req_t entry;
    int        eff_cap;
    int        best;
    int        k;
    res = '0;
    if (capacity_reg == 0) eff_cap = 1;
    else if (capacity_reg > QUEUE_DEPTH) eff_cap = QUEUE_DEPTH;
    else eff_cap = capacity_reg;
    if (req.op == OP_ENQUEUE) begin
      if (held_reqs.size() >= eff_cap) begin
        res.status = ST_FULL;
      end else begin
        entry.id  = req.id;
        entry.len = req.len;
        held_reqs.push_back(entry);
        res.status = ST_ACCEPTED;
      end
    end else if (held_reqs.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // Oldest under FIFO; shortest, oldest on a tie, under shortest-first
      best = 0;
      if (policy_reg == POLICY_SJN) begin
        for (k = 1; k < held_reqs.size(); k++)
          if (held_reqs[k].len < held_reqs[best].len) best = k;
      end
      res.status = ST_DEQUEUED;
      res.id     = held_reqs[best].id;
      res.len    = held_reqs[best].len;
      held_reqs.delete(best);
    end
    return res;
  endfunction

  function automatic request_t random_request(int enq_pct);
    request_t req;
    req.op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
    req.id = ID_W'($urandom_range(0, 65535));
    // Favour short lengths so that ties are common
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: req.len = $urandom_range(0, 7);
      5:             req.len = '0;
      6:             req.len = '1;
      default:       req.len = $urandom;
    endcase
    return req;
  endfunction

  task automatic queue_request(logic op, logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
    request_t req;
    req.op  = op;
    req.id  = id;
    req.len = len;
    pending_reqs.push_back(req);
    total_queued++;
  endtask

  // Hold until every queued transaction has produced its result
  task automatic wait_drained();
    while (results_seen != total_queued) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CAP_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_POLICY) policy_reg = val[0];
    else capacity_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic note_mismatch(string what, qresult_t exp_res, qresult_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected status %0d id %h len %h, got status %0d id %h len %h",
               what, exp_res.status, exp_res.id, exp_res.len,
               got.status, got.id, got.len);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input driver: advance to the next pending request once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid          <= 1'b0;
      in_bus.opcode         <= 1'b0;
      in_bus.request_id     <= '0;
      in_bus.request_length <= '0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        request_t req;
        req = pending_reqs.pop_front();
        in_bus.valid          <= 1'b1;
        in_bus.opcode         <= req.op;
        in_bus.request_id     <= req.id;
        in_bus.request_length <= req.len;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      request_t req;
      req.op  = in_bus.opcode;
      req.id  = in_bus.request_id;
      req.len = in_bus.request_length;
      expected_results.push_back(serve_request(req));
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result monitor: compare each accepted transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      qresult_t got;
      qresult_t exp_res;
      got.status = out_bus.status;
      got.id     = out_bus.out_id;
      got.len    = out_bus.out_length;
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        exp_res = expected_results.pop_front();
        if (got.status !== exp_res.status || got.id !== exp_res.id ||
            got.len !== exp_res.len)
          note_mismatch("result mismatch", exp_res, got);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int       ph;
    int       n;
    int       enq_pct;
    logic     ph_policy;
    logic [CAP_W-1:0] ph_cap;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= 1'b0;
    cfg_wdata      <= '0;
    policy_reg     = POLICY_FIFO;
    capacity_reg   = CAP_RESET;
    total_queued   = 0;
    results_seen   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 24;
    recv_idle_pct  = 50;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty dequeue, field extremes, fill to capacity, full, FIFO order
    queue_request(OP_DEQUEUE, 16'h0000, 32'h0);
    queue_request(OP_ENQUEUE, 16'h0000, 32'h0000_0000);
    queue_request(OP_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF);
    for (n = 0; n < QUEUE_DEPTH - 2; n++)
      queue_request(OP_ENQUEUE, 16'h0100 + ID_W'(n), n % 3 + 1);
    queue_request(OP_ENQUEUE, 16'hA5A5, 32'h5A5A_5A5A);
    queue_request(OP_DEQUEUE, 16'hFFFF, 32'hFFFF_FFFF);
    queue_request(OP_DEQUEUE, 16'h0000, 32'h0);
    wait_drained();

    // Switch to shortest-first with entries held, capacity below occupancy
    write_reg(CFG_POLICY, POLICY_SJN);
    write_reg(CFG_CAPACITY, 5'd0);
    queue_request(OP_ENQUEUE, 16'h1111, 32'h0);
    queue_request(OP_DEQUEUE, 16'h0, 32'h0);
    queue_request(OP_DEQUEUE, 16'h0, 32'h0);
    queue_request(OP_DEQUEUE, 16'h0, 32'h0);
    wait_drained();

    // Random phases with different settings and idle profiles
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin ph_policy = POLICY_SJN;  ph_cap = 5'd16; end
        1:       begin ph_policy = POLICY_FIFO; ph_cap = 5'd1;  end
        2:       begin ph_policy = POLICY_SJN;  ph_cap = 5'd31; end
        3:       begin ph_policy = POLICY_SJN;  ph_cap = 5'd5;  end
        4:       begin ph_policy = POLICY_FIFO; ph_cap = 5'd16; end
        default: begin ph_policy = POLICY_SJN;  ph_cap = 5'd3;  end
      endcase
      write_reg(CFG_POLICY, ph_policy);
      write_reg(CFG_CAPACITY, ph_cap);
      if (ph < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 50;
      end else if (ph < 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      enq_pct = 50;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Bursts biased towards filling or draining the queue
        if (n % 16 == 0) begin
          case ($urandom_range(0, 2))
            0:       enq_pct = 85;
            1:       enq_pct = 15;
            default: enq_pct = 50;
          endcase
        end
        // Sender pause midway through the first phase
        if (ph == 0 && n == PHASE_ITEMS / 2) wait_drained();
        pending_reqs.push_back(random_request(enq_pct));
        total_queued++;
      end
      wait_drained();
    end

    repeat (QUEUE_DEPTH * 4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
